>>> rtl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types for the circular deque
// Operation and status codes, the command broadcast to every cell and the
// record that a cell hands to its neighbors.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DataW = 32;

  typedef enum logic [1:0] {
    KIND_ADD_FRONT = 2'd0,
    KIND_ADD_REAR  = 2'd1,
    KIND_REM_FRONT = 2'd2,
    KIND_REM_REAR  = 2'd3
  } dq_kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } dq_status_t;

  // Command seen by every cell in the same cycle.
  typedef struct packed {
    logic     en;
    dq_kind_t kind;
  } dq_cmd_t;

  // Contents of one cell. fwd is the front-aligned copy (element k from the
  // front), bwd the rear-aligned copy (element k from the rear).
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] fwd;
    logic signed [DataW-1:0] bwd;
  } dq_cell_t;

endpackage

>>> rtl/dq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell: one position of the deque chain
// Holds one front-aligned and one rear-aligned element and shifts them to or
// from its neighbors on each executed command.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dq_pkg::dq_cmd_t                cmd,
  input  logic signed [dq_pkg::DataW-1:0] ins_value,
  input  dq_pkg::dq_cell_t               left_in,
  input  dq_pkg::dq_cell_t               right_in,
  output dq_pkg::dq_cell_t               state_out
);
  import dq_pkg::*;

  logic                    valid_r, valid_nxt;
  logic signed [DataW-1:0] fwd_r, fwd_nxt;
  logic signed [DataW-1:0] bwd_r, bwd_nxt;
  logic                    first_free;

  // First empty position of the occupied run: the append point of each copy.
  assign first_free = !valid_r && left_in.valid;

  always_comb begin
    valid_nxt = valid_r;
    fwd_nxt   = fwd_r;
    bwd_nxt   = bwd_r;
    if (cmd.en) begin
      unique case (cmd.kind)
        KIND_ADD_FRONT: begin
          valid_nxt = left_in.valid;
          fwd_nxt   = left_in.fwd;
          if (first_free) begin
            bwd_nxt = ins_value;
          end
        end
        KIND_ADD_REAR: begin
          valid_nxt = left_in.valid;
          bwd_nxt   = left_in.bwd;
          if (first_free) begin
            fwd_nxt = ins_value;
          end
        end
        KIND_REM_FRONT: begin
          valid_nxt = right_in.valid;
          fwd_nxt   = right_in.fwd;
        end
        KIND_REM_REAR: begin
          valid_nxt = right_in.valid;
          bwd_nxt   = right_in.bwd;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r <= fwd_nxt;
    bwd_r <= bwd_nxt;
  end

  assign state_out.valid = valid_r;
  assign state_out.fwd   = fwd_r;
  assign state_out.bwd   = bwd_r;

endmodule

>>> rtl/circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of signed 32-bit integers
// A chain of DEPTH cells keeps the contents twice, once aligned to the front
// and once to the rear, so both ends always sit in the first cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_kind selects add at front, add at
//   rear, remove front or remove rear; in_value is the element to add and is
//   ignored for removals.
//   Result channel (out_valid / out_stall): one transfer per input item with
//   out_status (done, rejected full, rejected empty), out_removed_value, the
//   front and rear elements after the operation (zero when empty) and the
//   empty / full flags.
//   The result is registered and valid in the cycle after the input transfer.
//   Throughput is one item per cycle unless the receiver stalls: every cell
//   updates from its neighbors in parallel, so the whole chain updates at once.
//   An add on a full deque or a remove on an empty one is rejected and leaves
//   the contents untouched.
//   Reset empties the deque and drops any pending result; there is no
//   clearing pass, the block accepts items as soon as reset is released.
//   While the receiver stalls a pending result, in_stall is raised and the
//   chain holds, so the front/rear/flag outputs stay with their result.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_kind,
  input  logic signed [dq_pkg::DataW-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic signed [dq_pkg::DataW-1:0] out_removed_value,
  output logic signed [dq_pkg::DataW-1:0] out_front_value,
  output logic signed [dq_pkg::DataW-1:0] out_rear_value,
  output logic                           out_is_empty,
  output logic                           out_is_full
);
  import dq_pkg::*;

  dq_cell_t                cell_q [DEPTH];
  dq_cell_t                head_feed;
  dq_cmd_t                 cmd;
  dq_kind_t                kind;
  dq_status_t              status_c;
  logic [DEPTH-1:0]        valid_vec;
  logic                    accept;
  logic                    is_add;
  logic                    full_now;
  logic                    empty_now;
  logic signed [DataW-1:0] removed_c;

  logic                    out_valid_r, out_valid_nxt;
  dq_status_t              out_status_r;
  logic signed [DataW-1:0] out_removed_r;

  // Take a new item whenever the result register is free or being drained.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign kind      = dq_kind_t'(in_kind);
  assign is_add    = (kind == KIND_ADD_FRONT) || (kind == KIND_ADD_REAR);
  assign full_now  = cell_q[DEPTH-1].valid;
  assign empty_now = !cell_q[0].valid;

  // Reject adds on a full deque and removes on an empty one.
  always_comb begin
    status_c = ST_DONE;
    if (is_add && full_now) begin
      status_c = ST_FULL;
    end else if (!is_add && empty_now) begin
      status_c = ST_EMPTY;
    end
  end

  // Both ends live in cell 0: the front copy and the rear copy.
  always_comb begin
    removed_c = '0;
    if (status_c == ST_DONE) begin
      if (kind == KIND_REM_FRONT) begin
        removed_c = cell_q[0].fwd;
      end else if (kind == KIND_REM_REAR) begin
        removed_c = cell_q[0].bwd;
      end
    end
  end

  assign cmd.en   = accept && (status_c == ST_DONE);
  assign cmd.kind = kind;

  // Feed for the front of the chain: a new element shifting in at cell 0.
  assign head_feed.valid = 1'b1;
  assign head_feed.fwd   = in_value;
  assign head_feed.bwd   = in_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_cell_t left_in;
    dq_cell_t right_in;
    if (i == 0) begin : g_first
      assign left_in = head_feed;
    end else begin : g_inner_l
      assign left_in = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner_r
      assign right_in = cell_q[i+1];
    end
    dq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .ins_value (in_value),
      .left_in   (left_in),
      .right_in  (right_in),
      .state_out (cell_q[i])
    );
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = cell_q[i].valid;
    end
  end

  // Result register: hold while stalled, load on every accepted item.
  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status_c;
      out_removed_r <= removed_c;
    end
  end

  // Front/rear/flags come straight off cell 0 and the last cell; the chain
  // does not move while a pending result is stalled, so they stay matched to it.
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_front_value   = cell_q[0].valid ? cell_q[0].fwd : '0;
  assign out_rear_value    = cell_q[0].valid ? cell_q[0].bwd : '0;
  assign out_is_empty      = !cell_q[0].valid;
  assign out_is_full       = cell_q[DEPTH-1].valid;

  // Occupied cells always form one run starting at cell 0.
  a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + {{(DEPTH-1){1'b0}}, 1'b1})) == '0)
    else $error("deque occupancy is not a contiguous run from cell 0");

  // With one element the front and rear copies must agree.
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_vec) == 1) |-> (cell_q[0].fwd == cell_q[0].bwd))
    else $error("front and rear copies differ for a single element");

  // A rejected operation leaves the occupancy untouched.
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (status_c != ST_DONE)) |=> $stable(valid_vec))
    else $error("rejected operation changed the deque");

  // A successful add always leaves the deque non-empty.
  a_add_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.en && is_add) |=> cell_q[0].valid)
    else $error("deque empty after a successful add");

endmodule
